FILE: sv/derz_pkg.sv
// ----------------------------------------------------------------------------
// derz_pkg
// Shared types, constants and elaboration-time helpers for the dual-energy
// log-ratio / effective atomic number pipeline.
// ----------------------------------------------------------------------------
package derz_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int ZEFF_W        = 15;
  localparam int MANT_W        = 32;
  localparam int LOG_ROUNDS    = 32;
  localparam int POW_STEPS     = 24;
  localparam int R24_W         = 26;

  // quadratic coefficients in Q16, exponent gain in Q24, exp gain in Q30
  localparam logic [23:0] QA       = 24'd8546360;
  localparam logic [21:0] QB       = 22'd2354113;
  localparam logic [19:0] QC       = 20'd998484;
  localparam logic [27:0] EXP_GAIN = 28'd163253286;
  localparam logic [27:0] EXP_K    = 28'd166334204;

  localparam logic [ZEFF_W-1:0] ZEFF_CEIL_RST = 15'd25600;

  typedef enum logic [1:0] {
    CFG_RATIO_LIMIT  = 2'd0,
    CFG_WINDOW_LOW   = 2'd1,
    CFG_WINDOW_HIGH  = 2'd2,
    CFG_ZEFF_CEILING = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic vld;
    logic fb;
  } derz_ctl_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bq;
    v   = v_in;
    res = '0;
    bq  = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bq > v) bq = bq >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bq != 64'd0) begin
        if (v >= res + bq) begin
          v   = v - (res + bq);
          res = (res >> 1) + bq;
        end else begin
          res = res >> 1;
        end
        bq = bq >> 2;
      end
    end
    return res;
  endfunction

  // square root of 1.0 taken i times in Q30, so every factor is 1.0
  function automatic logic [31:0] pow_factor(input int i);
    logic [63:0] c;
    c = 64'd1 << 30;
    for (int k = 1; k <= POW_STEPS; k++) begin
      if (k <= i) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

FILE: sv/dual_energy_ratio_zeff_top.sv
// ----------------------------------------------------------------------------
// dual_energy_ratio_zeff_top
// Per-pixel dual-energy log ratio and effective atomic number.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel item per handshake, low and high energy transmission
//           in unsigned Q1.FRAC_BITS.
//   out_* : ratio in Q(FRAC_BITS), Zeff in Q7.8 and the fallback flag,
//           one result item per input item, in order.
//   cfg_* : register writes (ratio limit, window bounds, Zeff ceiling),
//           taken on any cycle with cfg_wr_en high; write only when idle.
// Throughput: one item per cycle while the output is not stalled. Every step
//   of the log, divide and exponential chains is a pipeline stage of its own.
// Pipeline from input accept to out_valid: 34 log stages, FRAC_BITS + 5
//   divider stages, 27 Zeff stages and the output register.
// Reset: synchronous, active low; the pipeline empties and the registers
//   return to 1.5, 0.53, 0.85 and 100.0.
// Stall: while out_ready is low the output register holds its item; the
//   pipeline keeps moving until its last stage is occupied, then in_ready
//   drops until the output is taken. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dual_energy_ratio_zeff_top import derz_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int RW        = FRAC_BITS + 2,
  localparam int CFG_W     = (RW > ZEFF_W) ? RW : ZEFF_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FRAC_BITS:0] in_trans_low,
  input  logic [FRAC_BITS:0] in_trans_high,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [RW-1:0]      out_ratio_value,
  output logic [ZEFF_W-1:0]  out_zeff_value,
  output logic               out_fallback,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  localparam int NLW = $clog2(FRAC_BITS + 1) + MANT_W;
  localparam int ONE = 1 << FRAC_BITS;

  logic [RW-1:0]     ratio_limit_r;
  logic [RW-1:0]     window_low_r;
  logic [RW-1:0]     window_high_r;
  logic [ZEFF_W-1:0] zeff_ceiling_r;

  logic              en;
  logic              out_load;
  derz_ctl_t         lo_ctl;
  derz_ctl_t         hi_ctl;
  derz_ctl_t         div_in_ctl;
  derz_ctl_t         div_ctl;
  derz_ctl_t         zf_ctl;
  logic [NLW-1:0]    lo_nlog;
  logic [NLW-1:0]    hi_nlog;
  logic [RW-1:0]     div_ratio;
  logic [RW-1:0]     zf_ratio;
  logic [ZEFF_W-1:0] zf_zeff;

  logic              out_valid_r;
  logic [RW-1:0]     out_ratio_r;
  logic [ZEFF_W-1:0] out_zeff_r;
  logic              out_fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ratio_limit_r  <= RW'((3 * ONE) / 2);
      window_low_r   <= RW'((53 * ONE + 50) / 100);
      window_high_r  <= RW'((85 * ONE + 50) / 100);
      zeff_ceiling_r <= ZEFF_CEIL_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RATIO_LIMIT:  ratio_limit_r  <= cfg_wdata[RW-1:0];
        CFG_WINDOW_LOW:   window_low_r   <= cfg_wdata[RW-1:0];
        CFG_WINDOW_HIGH:  window_high_r  <= cfg_wdata[RW-1:0];
        CFG_ZEFF_CEILING: zeff_ceiling_r <= cfg_wdata[ZEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // output register frees itself or takes the last pipeline stage
  assign out_load = !out_valid_r || out_ready;
  assign en       = !zf_ctl.vld || out_load;
  assign in_ready = en;

  derz_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .x        (in_trans_low),
    .out_ctl  (lo_ctl),
    .out_nlog (lo_nlog)
  );

  derz_log2 #(.FRAC_BITS(FRAC_BITS)) u_log_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .x        (in_trans_high),
    .out_ctl  (hi_ctl),
    .out_nlog (hi_nlog)
  );

  assign div_in_ctl = '{vld: lo_ctl.vld && hi_ctl.vld, fb: lo_ctl.fb || hi_ctl.fb};

  derz_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_ctl      (div_in_ctl),
    .nh          (hi_nlog),
    .nl          (lo_nlog),
    .ratio_limit (ratio_limit_r),
    .out_ctl     (div_ctl),
    .out_ratio   (div_ratio)
  );

  derz_zeff #(.FRAC_BITS(FRAC_BITS)) u_zeff (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_ctl       (div_ctl),
    .in_ratio     (div_ratio),
    .window_low   (window_low_r),
    .window_high  (window_high_r),
    .zeff_ceiling (zeff_ceiling_r),
    .out_ctl      (zf_ctl),
    .out_ratio    (zf_ratio),
    .out_zeff     (zf_zeff)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= zf_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ratio_r <= zf_ratio;
      out_zeff_r  <= zf_zeff;
      out_fb_r    <= zf_ctl.fb;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_ratio_value = out_ratio_r;
  assign out_zeff_value  = out_zeff_r;
  assign out_fallback    = out_fb_r;

endmodule

FILE: sv/derz_log2.sv
// ----------------------------------------------------------------------------
// derz_log2
// Pipelined -log2 of a transmission value: normalize, then one
// square-and-compare round per stage, 32 fraction bits.
// ----------------------------------------------------------------------------
module derz_log2 import derz_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int NLW       = $clog2(FRAC_BITS + 1) + MANT_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [FRAC_BITS:0] x,
  output derz_ctl_t          out_ctl,
  output logic [NLW-1:0]     out_nlog
);

  localparam int PW = $clog2(FRAC_BITS);

  logic [PW-1:0]     p_enc;
  logic [MANT_W-1:0] m_init;

  derz_ctl_t         ctl_r [0:LOG_ROUNDS+1];
  logic [PW-1:0]     p_r   [0:LOG_ROUNDS];
  logic [MANT_W-1:0] m_r   [0:LOG_ROUNDS];
  logic [MANT_W-1:0] fr_r  [0:LOG_ROUNDS];
  logic [NLW-1:0]    nlog_r;

  // leading one and Q1.31 mantissa
  always_comb begin
    p_enc = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      if (x[i]) p_enc = PW'(i);
    end
    m_init = MANT_W'(x) << (MANT_W - 1 - int'(p_enc));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= '{vld: in_vld, fb: x[FRAC_BITS] || (x == '0)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0]  <= m_init;
      p_r[0]  <= p_enc;
      fr_r[0] <= '0;
    end
  end

  for (genvar k = 0; k < LOG_ROUNDS; k++) begin : g_round
    logic [2*MANT_W-1:0] sq;
    logic [MANT_W:0]     sh;

    assign sq = 64'(m_r[k]) * 64'(m_r[k]);
    assign sh = sq[2*MANT_W-1:MANT_W-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1]  <= sh[MANT_W] ? sh[MANT_W:1] : sh[MANT_W-1:0];
        fr_r[k+1] <= {fr_r[k][MANT_W-2:0], sh[MANT_W]};
        p_r[k+1]  <= p_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[LOG_ROUNDS+1] <= '0;
    end else if (en) begin
      ctl_r[LOG_ROUNDS+1] <= ctl_r[LOG_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlog_r <= (NLW'(FRAC_BITS - int'(p_r[LOG_ROUNDS])) << MANT_W)
                - NLW'(fr_r[LOG_ROUNDS]);
    end
  end

  assign out_ctl  = ctl_r[LOG_ROUNDS+1];
  assign out_nlog = nlog_r;

endmodule

FILE: sv/derz_div.sv
// ----------------------------------------------------------------------------
// derz_div
// Pipelined restoring divider for the rounded log ratio, one quotient bit
// per stage, with overflow, zero and limit checks.
// ----------------------------------------------------------------------------
module derz_div import derz_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int NLW       = $clog2(FRAC_BITS + 1) + MANT_W,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  derz_ctl_t      in_ctl,
  input  logic [NLW-1:0] nh,
  input  logic [NLW-1:0] nl,
  input  logic [RW-1:0]  ratio_limit,
  output derz_ctl_t      out_ctl,
  output logic [RW-1:0]  out_ratio
);

  localparam int DW       = NLW + RW;
  localparam int ONE      = 1 << FRAC_BITS;
  localparam int FB_RATIO = (ONE + 50) / 100;

  derz_ctl_t      ctl0_r;
  logic [DW-1:0]  num_r;
  logic [NLW-1:0] d0_r;

  derz_ctl_t      ctlq_r [0:RW];
  logic [RW-1:0]  q_r    [0:RW];
  logic [DW-1:0]  rem_r  [0:RW-1];
  logic [NLW-1:0] dq_r   [0:RW-1];

  derz_ctl_t      ctlo_r;
  logic [RW-1:0]  ratio_r;
  logic           fb_fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl0_r    <= '0;
      ctlq_r[0] <= '0;
    end else if (en) begin
      ctl0_r    <= in_ctl;
      // quotient past the ratio width always exceeds the limit
      ctlq_r[0] <= '{vld: ctl0_r.vld,
                     fb: ctl0_r.fb || (num_r >= (DW'(d0_r) << RW))};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r    <= (DW'(nh) << FRAC_BITS) + DW'(nl >> 1);
      d0_r     <= nl;
      rem_r[0] <= num_r;
      dq_r[0]  <= d0_r;
      q_r[0]   <= '0;
    end
  end

  for (genvar j = 0; j < RW; j++) begin : g_step
    localparam int SB = RW - 1 - j;
    logic [DW-1:0] sub;
    logic          take;

    assign sub  = DW'(dq_r[j]) << SB;
    assign take = rem_r[j] >= sub;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctlq_r[j+1] <= '0;
      end else if (en) begin
        ctlq_r[j+1] <= ctlq_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j+1] <= take ? (q_r[j] | (RW'(1) << SB)) : q_r[j];
      end
    end

    if (j < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= take ? (rem_r[j] - sub) : rem_r[j];
          dq_r[j+1]  <= dq_r[j];
        end
      end
    end
  end

  assign fb_fin = ctlq_r[RW].fb || (q_r[RW] > ratio_limit) || (q_r[RW] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctlo_r <= '0;
    end else if (en) begin
      ctlo_r <= '{vld: ctlq_r[RW].vld, fb: fb_fin};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ratio_r <= fb_fin ? RW'(FB_RATIO) : q_r[RW];
    end
  end

  assign out_ctl   = ctlo_r;
  assign out_ratio = ratio_r;

endmodule

FILE: sv/derz_zeff.sv
// ----------------------------------------------------------------------------
// derz_zeff
// Effective atomic number from the ratio: quadratic inside the window,
// exponential through a chain of pow_factor multiply stages outside it.
// ----------------------------------------------------------------------------
module derz_zeff import derz_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int RW        = FRAC_BITS + 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  derz_ctl_t         in_ctl,
  input  logic [RW-1:0]     in_ratio,
  input  logic [RW-1:0]     window_low,
  input  logic [RW-1:0]     window_high,
  input  logic [ZEFF_W-1:0] zeff_ceiling,
  output derz_ctl_t         out_ctl,
  output logic [RW-1:0]     out_ratio,
  output logic [ZEFF_W-1:0] out_zeff
);

  localparam int LAST = POW_STEPS + 2;
  localparam int PE_W = 54;
  localparam int QS_W = 52;
  localparam int QB_W = 48;
  localparam int QA_W = 52;
  localparam int ZQ_W = 22;
  localparam int PW_W = 31;
  localparam int ZK_W = 29;

  logic [R24_W-1:0] r24;
  logic [PE_W-1:0]  e_sum;
  logic [55:0]      z40;
  logic [55:0]      z_rnd;
  logic [ZQ_W-1:0]  zq_new;
  logic [63:0]      ez;
  logic [63:0]      zsel;

  derz_ctl_t        ctl_r [0:LAST];
  logic [RW-1:0]    r_r   [0:LAST];
  logic             win_r [0:LAST];
  logic [5:0]       n_r   [1:LAST];
  logic [23:0]      f_r   [1:POW_STEPS];
  logic [PW_W-1:0]  pw_r  [1:POW_STEPS+1];
  logic [ZQ_W-1:0]  zq_r  [2:LAST];

  logic [PE_W-1:0]  pe_r;
  logic [QS_W-1:0]  qs_r;
  logic [QB_W-1:0]  qb0_r;
  logic [QA_W-1:0]  qa_r;
  logic [QB_W-1:0]  qb1_r;
  logic [ZK_W-1:0]  zk_r;

  assign r24 = R24_W'(in_ratio) << (24 - FRAC_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (en) begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= in_ratio;
      win_r[0] <= (in_ratio > window_low) && (in_ratio < window_high);
      pe_r     <= PE_W'(EXP_GAIN) * PE_W'(r24);
      qs_r     <= QS_W'(r24) * QS_W'(r24);
      qb0_r    <= QB_W'(QB) * QB_W'(r24);
    end
  end

  // exponent rounded to Q24, r^2 truncated to Q24
  assign e_sum = pe_r + (PE_W'(1) << 23);

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[1]  <= e_sum[53:48];
      f_r[1]  <= e_sum[47:24];
      pw_r[1] <= PW_W'(1) << 30;
      qa_r    <= QA_W'(QA) * QA_W'(qs_r[51:24]);
      qb1_r   <= qb0_r;
    end
  end

  assign z40    = {4'b0, qa_r} - 56'(qb1_r) - (56'(QC) << 24);
  assign z_rnd  = z40 + (56'd1 << 31);
  assign zq_new = (z40[55] || (z40 == '0)) ? '0 : z_rnd[32 +: ZQ_W];

  for (genvar k = 0; k <= POW_STEPS + 1; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else if (en) begin
        ctl_r[k+1] <= ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1]   <= r_r[k];
        win_r[k+1] <= win_r[k];
      end
    end
  end

  for (genvar k = 1; k <= POW_STEPS + 1; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k+1] <= n_r[k];
        if (k == 1) begin
          zq_r[k+1] <= zq_new;
        end else begin
          zq_r[k+1] <= zq_r[k];
        end
      end
    end
  end

  for (genvar k = 1; k <= POW_STEPS; k++) begin : g_pow
    localparam logic [31:0] C_K = pow_factor(k);
    logic [63:0] prod;

    assign prod = 64'(pw_r[k]) * 64'(C_K);

    always_ff @(posedge clk) begin
      if (en) begin
        pw_r[k+1] <= f_r[k][POW_STEPS-k] ? prod[30 +: PW_W] : pw_r[k];
      end
    end

    if (k < POW_STEPS) begin : g_f
      always_ff @(posedge clk) begin
        if (en) begin
          f_r[k+1] <= f_r[k];
        end
      end
    end
  end

  logic [58:0] zk_prod;
  assign zk_prod = 59'(EXP_K) * 59'(pw_r[POW_STEPS+1]);

  always_ff @(posedge clk) begin
    if (en) begin
      zk_r <= zk_prod[30 +: ZK_W];
    end
  end

  always_comb begin
    if (n_r[LAST] >= 6'd30) begin
      ez = 64'(zeff_ceiling);
    end else begin
      ez = ((64'(zk_r) << n_r[LAST]) + (64'd1 << 21)) >> 22;
    end
    zsel = win_r[LAST] ? 64'(zq_r[LAST]) : ez;
    out_zeff = (zsel > 64'(zeff_ceiling)) ? zeff_ceiling : zsel[ZEFF_W-1:0];
  end

  assign out_ctl   = ctl_r[LAST];
  assign out_ratio = r_r[LAST];

endmodule

FILE: sv/derz_checker.sv
// ----------------------------------------------------------------------------
// derz_checker
// Port-level checks for the dual-energy ratio / Zeff block, bound to the
// top level.
// ----------------------------------------------------------------------------
module derz_checker import derz_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int RW        = FRAC_BITS + 2,
  localparam int CFG_W     = (RW > ZEFF_W) ? RW : ZEFF_W
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic [FRAC_BITS:0] in_trans_low,
  input logic [FRAC_BITS:0] in_trans_high,
  input logic               out_valid,
  input logic               out_ready,
  input logic [RW-1:0]      out_ratio_value,
  input logic [ZEFF_W-1:0]  out_zeff_value,
  input logic               out_fallback,
  input logic               cfg_wr_en,
  input logic [1:0]         cfg_index,
  input logic [CFG_W-1:0]   cfg_wdata
);

  localparam int ONE      = 1 << FRAC_BITS;
  localparam int FB_RATIO = (ONE + 50) / 100;

  logic [ZEFF_W-1:0] ceil_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r <= ZEFF_CEIL_RST;
    end else if (cfg_wr_en && (cfg_idx_t'(cfg_index) == CFG_ZEFF_CEILING)) begin
      ceil_r <= cfg_wdata[ZEFF_W-1:0];
    end
  end

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ratio_value)
      && $stable(out_zeff_value) && $stable(out_fallback))
    else $error("result item changed while stalled");

  // an empty output register never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  a_fb_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fallback |-> out_ratio_value == RW'(FB_RATIO))
    else $error("fallback item without fallback ratio");

  a_ratio_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fallback |-> out_ratio_value != '0)
    else $error("zero ratio without fallback");

  a_zeff_ceil: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_zeff_value <= ceil_r)
    else $error("zeff above ceiling");

endmodule

bind dual_energy_ratio_zeff_top derz_checker #(.FRAC_BITS(FRAC_BITS)) u_derz_checker (.*);
